// File: rtl/core/ordered_list_engine_defines.svh
// Assertion macros shared by the list engine RTL.
// Included by files that carry concurrent checks; needs no package.
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define OLE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define OLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ole_pkg.sv
// Shared types and constants of the ordered list engine.
// No dependencies; compiled before every other RTL file.
package ole_pkg;

    // Default sizes of the node pool
    localparam int CAPACITY_DEF   = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the command and result channels
    localparam int CMD_W  = 4;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 7;
    localparam int STAT_W = 2;

    // Most results one read-all transaction produces
    localparam int MAX_OUT = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT  = 4'd0,
        CMD_INS_BACK   = 4'd1,
        CMD_INS_BEFORE = 4'd2,
        CMD_INS_AFTER  = 4'd3,
        CMD_DEL_FRONT  = 4'd4,
        CMD_DEL_BACK   = 4'd5,
        CMD_DEL_KEY    = 4'd6,
        CMD_SEARCH     = 4'd7,
        CMD_READ_ALL   = 4'd8
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_ALLOC,
        S_ALLOC_WAIT,
        S_WR1,
        S_WR2,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_status                   status;
        logic [POS_W-1:0]          position;
        logic signed [VAL_W-1:0]   item_value;
        logic                      last;
    } t_result;

endpackage

// File: rtl/core/ole_cmd_if.sv
// Command channel of the list engine: valid/ready plus command payload.
// Depends on ole_pkg for field widths.
interface ole_cmd_if import ole_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] new_value;
    logic signed [VAL_W-1:0] match_key;

    modport source (output valid, output cmd, output new_value, output match_key,
                    input ready);
    modport sink   (input valid, input cmd, input new_value, input match_key,
                    output ready);
endinterface

// File: rtl/core/ole_res_if.sv
// Result channel of the list engine: valid/ready plus result payload.
// Depends on ole_pkg for field widths.
interface ole_res_if import ole_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
    logic                    last;

    modport source (output valid, output status, output position, output item_value,
                    output last, input ready);
    modport sink   (input valid, input status, input position, input item_value,
                    input last, output ready);
endinterface

// File: rtl/core/ole_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on ole_pkg for default sizes.
module ole_ram import ole_pkg::*; #(
    parameter int WIDTH = DATA_WIDTH_DEF,
    parameter int DEPTH = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; hold the last data while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/ole_out_reg.sv
// Output register of the list engine: parts the sequencer from the result channel.
// Depends on ole_pkg (t_result) and ole_res_if.
module ole_out_reg import ole_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_result   i_result,
    output logic      o_ready,
    ole_res_if.source o_res
);

    logic    r_valid;
    t_result r_result;

    // Take a new result when empty or when the held one leaves this cycle
    assign o_ready = !r_valid || o_res.ready;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Load payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.status     = r_result.status;
    assign o_res.position   = r_result.position;
    assign o_res.item_value = r_result.item_value;
    assign o_res.last       = r_result.last;

endmodule

// File: rtl/core/ole_ctrl.sv
// Sequencer of the list engine: walks the linked node pool, allocates and frees slots.
// Depends on ole_pkg and ole_cmd_if; drives the value and link RAMs.
module ole_ctrl import ole_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ole_cmd_if.sink                     i_cmd,
    input  logic                        i_out_ready,
    output logic                        o_push,
    output t_result                     o_result,
    output logic [$clog2(CAPACITY)-1:0] o_raddr,
    output logic                        o_val_re,
    output logic                        o_link_re,
    input  logic [DATA_WIDTH-1:0]       i_val_rdata,
    input  logic [$clog2(CAPACITY)-1:0] i_link_rdata,
    output logic                        o_val_we,
    output logic [$clog2(CAPACITY)-1:0] o_val_waddr,
    output logic [DATA_WIDTH-1:0]       o_val_wdata,
    output logic                        o_link_we,
    output logic [$clog2(CAPACITY)-1:0] o_link_waddr,
    output logic [$clog2(CAPACITY)-1:0] o_link_wdata
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Control state
    t_state          r_state, n_state;
    logic [SW-1:0]   r_head, n_head;
    logic [SW-1:0]   r_free_head, n_free_head;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_fresh, n_fresh;

    // Transaction payload and walk position
    t_cmd            r_cmd, n_cmd;
    logic [DATA_WIDTH-1:0] r_nv, n_nv;
    logic [DATA_WIDTH-1:0] r_key, n_key;
    logic [SW-1:0]   r_cur, n_cur;
    logic [SW-1:0]   r_prev, n_prev;
    logic [SW-1:0]   r_cur_link, n_cur_link;
    logic [SW-1:0]   r_slot, n_slot;
    logic [SW-1:0]   r_idx, n_idx;
    t_status         r_status, n_status;
    logic [POS_W-1:0] r_pos, n_pos;

    // Decode helpers
    t_cmd                  in_cmd;
    logic                  in_known;
    logic                  in_is_ins;
    logic                  accept;
    logic signed [63:0]    nv_ext;
    logic signed [63:0]    key_ext;
    logic signed [63:0]    rd_ext;
    logic                  full;
    logic                  empty;
    logic                  one_left;
    logic                  recycled;
    logic                  r_is_ins;
    logic                  need2;
    logic                  match;
    logic                  at_end;
    logic                  read_last;
    logic                  walk_stop;
    logic                  walk_adv;
    logic                  want_push;

    assign in_cmd    = t_cmd'(i_cmd.cmd);
    assign in_known  = in_cmd inside {[CMD_INS_FRONT:CMD_READ_ALL]};
    assign in_is_ins = in_cmd inside {[CMD_INS_FRONT:CMD_INS_AFTER]};
    assign accept    = i_cmd.valid && i_cmd.ready;

    // Sign-extend the 32-bit fields, then cut to the stored width
    assign nv_ext  = 64'(i_cmd.new_value);
    assign key_ext = 64'(i_cmd.match_key);
    assign rd_ext  = 64'(signed'(i_val_rdata));

    assign full      = (r_count == CW'(CAPACITY));
    assign empty     = (r_count == '0);
    assign one_left  = (r_count == CW'(1));
    assign recycled  = (r_fresh != r_count);
    assign r_is_ins  = r_cmd inside {[CMD_INS_FRONT:CMD_INS_AFTER]};
    assign need2     = ((r_cmd == CMD_INS_BEFORE) && (r_idx != '0))
                    || (r_cmd == CMD_INS_AFTER)
                    || ((r_cmd == CMD_DEL_KEY) && (r_idx != '0));

    // Walk: read data belongs to r_cur at position r_idx
    assign match     = (i_val_rdata == r_key);
    assign at_end    = ((CW'(r_idx) + CW'(1)) == r_count);
    assign read_last = at_end || (POS_W'(r_idx) == POS_W'(MAX_OUT - 1));

    // Decide where the walk ends for each command
    always_comb begin
        case (r_cmd)
            CMD_INS_BACK, CMD_DEL_BACK: begin
                walk_stop = at_end;
            end
            CMD_INS_BEFORE, CMD_INS_AFTER, CMD_DEL_KEY, CMD_SEARCH: begin
                walk_stop = match || at_end;
            end
            CMD_READ_ALL: begin
                walk_stop = read_last;
            end
            default: begin
                walk_stop = 1'b1;
            end
        endcase
    end

    assign walk_adv = (r_state == S_WALK) && !walk_stop
                   && ((r_cmd != CMD_READ_ALL) || i_out_ready);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && in_known) begin
                    if (in_is_ins && full) begin
                        n_state = S_EMIT;
                    end else if (!(in_cmd == CMD_INS_FRONT || in_cmd == CMD_INS_BACK)
                                 && empty) begin
                        n_state = S_EMIT;
                    end else if (in_cmd == CMD_INS_FRONT
                                 || (in_cmd == CMD_INS_BACK && empty)) begin
                        n_state = S_ALLOC;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                case (r_cmd)
                    CMD_INS_BACK: begin
                        if (at_end) n_state = S_ALLOC;
                    end
                    CMD_DEL_BACK: begin
                        if (at_end) n_state = S_WR1;
                    end
                    CMD_DEL_FRONT: begin
                        n_state = S_WR1;
                    end
                    CMD_INS_BEFORE, CMD_INS_AFTER: begin
                        if (match) n_state = S_ALLOC;
                        else if (at_end) n_state = S_EMIT;
                    end
                    CMD_DEL_KEY: begin
                        if (match) n_state = S_WR1;
                        else if (at_end) n_state = S_EMIT;
                    end
                    CMD_SEARCH: begin
                        if (match || at_end) n_state = S_EMIT;
                    end
                    CMD_READ_ALL: begin
                        if (i_out_ready && read_last) n_state = S_IDLE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_ALLOC: begin
                n_state = recycled ? S_ALLOC_WAIT : S_WR1;
            end
            S_ALLOC_WAIT: begin
                n_state = S_WR1;
            end
            S_WR1: begin
                n_state = need2 ? S_WR2 : S_EMIT;
            end
            S_WR2: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and list bookkeeping
    always_comb begin
        n_head      = r_head;
        n_free_head = r_free_head;
        n_count     = r_count;
        n_fresh     = r_fresh;
        n_cmd       = r_cmd;
        n_nv        = r_nv;
        n_key       = r_key;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_cur_link  = r_cur_link;
        n_slot      = r_slot;
        n_idx       = r_idx;
        n_status    = r_status;
        n_pos       = r_pos;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd    = in_cmd;
                    n_nv     = nv_ext[DATA_WIDTH-1:0];
                    n_key    = key_ext[DATA_WIDTH-1:0];
                    n_cur    = r_head;
                    n_prev   = r_head;
                    n_idx    = '0;
                    n_pos    = '0;
                    n_status = (in_is_ins && full) ? ST_FULL : ST_EMPTY;
                end
            end
            S_WALK: begin
                if (walk_adv) begin
                    n_prev = r_cur;
                    n_cur  = i_link_rdata;
                    n_idx  = r_idx + SW'(1);
                end else if (walk_stop) begin
                    n_cur_link = i_link_rdata;
                    n_status   = match ? ST_OK : ST_NOT_FOUND;
                    n_pos      = match ? (POS_W'(r_idx) + POS_W'(1)) : '0;
                end
            end
            S_ALLOC: begin
                // Reuse a freed slot first, else take the next never-used one
                if (recycled) begin
                    n_slot = r_free_head;
                end else begin
                    n_slot  = r_fresh[SW-1:0];
                    n_fresh = r_fresh + CW'(1);
                end
            end
            S_ALLOC_WAIT: begin
                n_free_head = i_link_rdata;
            end
            S_WR1: begin
                n_status = ST_OK;
                n_pos    = '0;
                if (r_is_ins) begin
                    n_count = r_count + CW'(1);
                    if (r_cmd == CMD_INS_FRONT
                        || (r_cmd == CMD_INS_BACK && empty)
                        || (r_cmd == CMD_INS_BEFORE && r_idx == '0)) begin
                        n_head = r_slot;
                    end
                end else begin
                    n_count     = r_count - CW'(1);
                    n_free_head = r_cur;
                    if (r_cmd == CMD_DEL_FRONT
                        || (r_cmd == CMD_DEL_KEY && r_idx == '0)) begin
                        n_head = one_left ? '0 : r_cur_link;
                    end else if (r_cmd == CMD_DEL_BACK && one_left) begin
                        n_head = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Memory accesses, handshake and results
    always_comb begin
        i_cmd.ready  = (r_state == S_IDLE);
        o_raddr      = r_head;
        o_val_re     = 1'b0;
        o_link_re    = 1'b0;
        o_val_we     = 1'b0;
        o_val_waddr  = r_slot;
        o_val_wdata  = r_nv;
        o_link_we    = 1'b0;
        o_link_waddr = r_slot;
        o_link_wdata = r_cur;
        want_push    = 1'b0;
        o_result     = '{status: r_status, position: r_pos, item_value: '0, last: 1'b1};
        case (r_state)
            S_IDLE: begin
                // Start the walk at the head as the transaction is taken
                o_val_re  = accept;
                o_link_re = accept;
            end
            S_WALK: begin
                o_raddr   = i_link_rdata;
                o_val_re  = walk_adv;
                o_link_re = walk_adv;
                if (r_cmd == CMD_READ_ALL) begin
                    want_push = 1'b1;
                    o_result  = '{status: ST_OK, position: '0,
                                  item_value: rd_ext[VAL_W-1:0], last: read_last};
                end
            end
            S_ALLOC: begin
                o_raddr   = r_free_head;
                o_link_re = recycled;
            end
            S_WR1: begin
                o_val_we = r_is_ins;
                case (r_cmd)
                    CMD_INS_FRONT: begin
                        o_link_we    = 1'b1;
                        o_link_waddr = r_slot;
                        o_link_wdata = r_head;
                    end
                    CMD_INS_BACK: begin
                        o_link_we    = !empty;
                        o_link_waddr = r_cur;
                        o_link_wdata = r_slot;
                    end
                    CMD_INS_BEFORE: begin
                        o_link_we    = 1'b1;
                        o_link_waddr = r_slot;
                        o_link_wdata = r_cur;
                    end
                    CMD_INS_AFTER: begin
                        o_link_we    = 1'b1;
                        o_link_waddr = r_slot;
                        o_link_wdata = r_cur_link;
                    end
                    CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_KEY: begin
                        // Push the freed slot on the free chain
                        o_link_we    = 1'b1;
                        o_link_waddr = r_cur;
                        o_link_wdata = r_free_head;
                    end
                    default: begin
                    end
                endcase
            end
            S_WR2: begin
                case (r_cmd)
                    CMD_INS_BEFORE: begin
                        o_link_we    = 1'b1;
                        o_link_waddr = r_prev;
                        o_link_wdata = r_slot;
                    end
                    CMD_INS_AFTER: begin
                        o_link_we    = 1'b1;
                        o_link_waddr = r_cur;
                        o_link_wdata = r_slot;
                    end
                    CMD_DEL_KEY: begin
                        o_link_we    = 1'b1;
                        o_link_waddr = r_prev;
                        o_link_wdata = r_cur_link;
                    end
                    default: begin
                    end
                endcase
            end
            S_EMIT: begin
                want_push = 1'b1;
            end
            default: begin
            end
        endcase
        o_push = want_push && i_out_ready;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_free_head <= '0;
            r_count     <= '0;
            r_fresh     <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_free_head <= n_free_head;
            r_count     <= n_count;
            r_fresh     <= n_fresh;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_nv       <= n_nv;
        r_key      <= n_key;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_cur_link <= n_cur_link;
        r_slot     <= n_slot;
        r_idx      <= n_idx;
        r_status   <= n_status;
        r_pos      <= n_pos;
    end

endmodule

// File: rtl/core/ordered_list_engine.sv
// Top level of the ordered list engine: sequencer, value and link RAMs, output register.
// Depends on ole_pkg, ole_cmd_if, ole_res_if, ole_ram, ole_ctrl, ole_out_reg.
//
//  Channel | Direction | Handshake   | Payload
//  i_cmd   | in        | valid/ready | cmd, new_value, match_key
//  o_res   | out       | valid/ready | status, position, item_value, last
//
// A list walk reads one node per cycle through the single read port of the link RAM
// and visits at most CAPACITY nodes; a stalled result channel holds a read-all walk
// and the emit of a result. Reset clears head, free chain head, entry count and fill
// count; slots are handed out in order from the fill count, so the RAMs need no
// clearing pass. A new command is taken while a result waits in the output register.
`include "ordered_list_engine_defines.svh"

module ordered_list_engine import ole_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ole_cmd_if.sink   i_cmd,
    ole_res_if.source o_res
);

    localparam int SW = $clog2(CAPACITY);

    logic                  out_ready;
    logic                  push;
    t_result               result;
    logic [SW-1:0]         raddr;
    logic                  val_re;
    logic                  link_re;
    logic [DATA_WIDTH-1:0] val_rdata;
    logic [SW-1:0]         link_rdata;
    logic                  val_we;
    logic [SW-1:0]         val_waddr;
    logic [DATA_WIDTH-1:0] val_wdata;
    logic                  link_we;
    logic [SW-1:0]         link_waddr;
    logic [SW-1:0]         link_wdata;

    // Sequencer
    ole_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_out_ready  (out_ready),
        .o_push       (push),
        .o_result     (result),
        .o_raddr      (raddr),
        .o_val_re     (val_re),
        .o_link_re    (link_re),
        .i_val_rdata  (val_rdata),
        .i_link_rdata (link_rdata),
        .o_val_we     (val_we),
        .o_val_waddr  (val_waddr),
        .o_val_wdata  (val_wdata),
        .o_link_we    (link_we),
        .o_link_waddr (link_waddr),
        .o_link_wdata (link_wdata)
    );

    // Node values
    ole_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_re    (val_re),
        .i_raddr (raddr),
        .o_rdata (val_rdata)
    );

    // Next links of list and free chain
    ole_ram #(
        .WIDTH (SW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (raddr),
        .o_rdata (link_rdata)
    );

    // Result register
    ole_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (result),
        .o_ready  (out_ready),
        .o_res    (o_res)
    );

    // Checks
    `OLE_ASSERT_SAME(a_link_rw_apart, i_clk, i_rst_n, link_we, !link_re, "link RAM read during write")
    `OLE_ASSERT_SAME(a_val_read_with_link, i_clk, i_rst_n, val_re, link_re, "value read without link read")
    `OLE_ASSERT_SAME(a_push_has_room, i_clk, i_rst_n, push, out_ready, "result pushed into full register")
    `OLE_ASSERT_NEXT(a_busy_after_cmd, i_clk, i_rst_n, i_cmd.valid && i_cmd.ready && (i_cmd.cmd <= CMD_READ_ALL), !i_cmd.ready, "new transaction taken while busy")

endmodule

// File: sim/ordered_list_engine_test.sv
// Self-checking testbench for ordered_list_engine: directed and random list commands
// with a queue-based list predictor. Needs ole_pkg, ole_cmd_if, ole_res_if and the RTL.
`timescale 1ns / 100ps

module ordered_list_engine_test;
    import ole_pkg::*;

    localparam int CAPACITY      = CAPACITY_DEF;
    localparam int RUN_LIMIT     = 200000;
    localparam int DRAIN_CYCLES  = 3 * CAPACITY;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_PCT      = 14;
    localparam int BLOCK_ITEMS   = 25;
    localparam int NUM_BLOCKS    = 8;
    localparam int STEADY_BLOCK  = 3;
    localparam int HOLD_BLOCK    = 1;
    // Share of inserts per random block: grow to full, then mix, drain, mix, regrow
    localparam int INSERT_SHARE [NUM_BLOCKS] = '{80, 80, 80, 45, 20, 20, 45, 60};

    localparam logic [CMD_W-1:0] CMD_RESERVED_MIN = 4'd9;
    localparam logic [CMD_W-1:0] CMD_RESERVED_MAX = 4'd15;

    // List predictor and store of expected results
    class ListScoreboard;
        int                      capacity;
        logic signed [VAL_W-1:0] entries[$];
        t_result                 awaited[$];
        int                      errors;
        int                      cmds_taken;
        int                      cmds_ignored;
        int                      results_seen;
        int                      full_rejects;
        int                      key_misses;
        int                      empty_rejects;
        int                      peak_depth;

        function new(int cap);
            capacity = cap;
        endfunction

        function int find_first(logic signed [VAL_W-1:0] key);
            foreach (entries[i]) begin
                if (entries[i] == key) return i;
            end
            return -1;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Update the list for one accepted command and queue what it produces
        function void note_command(logic [CMD_W-1:0] code, logic signed [VAL_W-1:0] nv,
                                   logic signed [VAL_W-1:0] key);
            int      idx;
            int      n;
            t_result r;
            r = '{status: ST_OK, position: '0, item_value: '0, last: 1'b1};
            cmds_taken++;
            if (code > CMD_READ_ALL) begin
                cmds_ignored++;
                return;
            end
            idx = find_first(key);
            if (code <= CMD_INS_AFTER && entries.size() >= capacity) begin
                r.status = ST_FULL;
                full_rejects++;
            end else if (code != CMD_INS_FRONT && code != CMD_INS_BACK
                         && entries.size() == 0) begin
                r.status = ST_EMPTY;
                empty_rejects++;
            end else begin
                case (code)
                    CMD_INS_FRONT: entries.push_front(nv);
                    CMD_INS_BACK:  entries.push_back(nv);
                    CMD_INS_BEFORE, CMD_INS_AFTER: begin
                        if (idx < 0) r.status = ST_NOT_FOUND;
                        else entries.insert((code == CMD_INS_AFTER) ? idx + 1 : idx, nv);
                    end
                    CMD_DEL_FRONT: void'(entries.pop_front());
                    CMD_DEL_BACK:  void'(entries.pop_back());
                    CMD_DEL_KEY: begin
                        if (idx < 0) r.status = ST_NOT_FOUND;
                        else entries.delete(idx);
                    end
                    CMD_SEARCH: begin
                        if (idx < 0) r.status = ST_NOT_FOUND;
                        else r.position = POS_W'(idx + 1);
                    end
                    default: begin
                        // Read-all: one result per entry, capped at MAX_OUT
                        n = (entries.size() < MAX_OUT) ? entries.size() : MAX_OUT;
                        for (int i = 0; i < n; i++) begin
                            r.item_value = entries[i];
                            r.last       = (i == n - 1);
                            awaited.push_back(r);
                        end
                        return;
                    end
                endcase
                if (r.status == ST_NOT_FOUND) key_misses++;
            end
            if (entries.size() > peak_depth) peak_depth = entries.size();
            awaited.push_back(r);
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(t_result got);
            t_result want;
            results_seen++;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result status=%0d pos=%0d value=%0d last=%0d",
                         $time, got.status, got.position, got.item_value, got.last);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.position !== want.position) begin
                $display("%0t: position expected %0d, got %0d",
                         $time, want.position, got.position);
                errors++;
            end
            if (got.item_value !== want.item_value) begin
                $display("%0t: item_value expected %0d, got %0d",
                         $time, want.item_value, got.item_value);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0d, got %0d", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycles  = 0;
    bit   steady  = 1'b0;
    bit   hold_req  = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_left = 0;
    ListScoreboard board = new(CAPACITY);

    ole_cmd_if cmd_if();
    ole_res_if res_if();

    ordered_list_engine #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH_DEF)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // Clock
    always #6 i_clk = ~i_clk;

    // Guard against a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, board.pending());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Check every result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            board.check_result('{status: t_status'(res_if.status), position: res_if.position,
                                 item_value: res_if.item_value, last: res_if.last});
        end
    end

    // Drive result ready: random stalls, one long hold-off, none while steady
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Offer one command and wait until it is taken
    task automatic send(logic [CMD_W-1:0] code, logic signed [VAL_W-1:0] nv,
                        logic signed [VAL_W-1:0] key);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.cmd       <= code;
        cmd_if.new_value <= nv;
        cmd_if.match_key <= key;
        do @(posedge i_clk); while (!cmd_if.ready);
        board.note_command(code, nv, key);
    endtask

    // Small values so keys repeat, extremes, and mostly full-range noise
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom_range(8) - 4;
            1: begin
                case ($urandom_range(3))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    2:       return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Prefer keys that are in the list so that key commands reach deep
    function automatic logic signed [VAL_W-1:0] pick_key();
        if (board.entries.size() > 0 && $urandom_range(99) < 70)
            return board.entries[$urandom_range(board.entries.size() - 1)];
        return pick_value();
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(int ins_pct);
        int r;
        r = $urandom_range(99);
        if (r < ins_pct) return CMD_W'($urandom_range(CMD_INS_AFTER, CMD_INS_FRONT));
        if (r < 98)      return CMD_W'($urandom_range(CMD_READ_ALL, CMD_DEL_FRONT));
        return CMD_W'($urandom_range(CMD_RESERVED_MAX, CMD_RESERVED_MIN));
    endfunction

    // Main sequence
    initial begin
        cmd_if.valid     = 1'b0;
        cmd_if.cmd       = CMD_INS_FRONT;
        cmd_if.new_value = '0;
        cmd_if.match_key = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list: read-all and every command that needs an entry
        send(CMD_READ_ALL,   0, 0);
        send(CMD_DEL_FRONT,  0, 0);
        send(CMD_DEL_BACK,   0, 0);
        send(CMD_DEL_KEY,    0, 7);
        send(CMD_SEARCH,     0, 7);
        send(CMD_INS_BEFORE, 1, 7);
        send(CMD_INS_AFTER,  1, 7);
        // Extreme values at both ends
        send(CMD_INS_FRONT,  32'sh7FFF_FFFF, 0);
        send(CMD_INS_BACK,   32'sh8000_0000, 0);
        send(CMD_INS_FRONT,  0, 0);
        send(CMD_INS_BACK,   -1, 0);
        // Insert before the head, after the tail, and with a missing key
        send(CMD_INS_BEFORE, 5, 0);
        send(CMD_INS_AFTER,  32'sh55AA_55AA, -1);
        send(CMD_INS_BEFORE, 9, 12345);
        send(CMD_SEARCH,     0, 32'sh55AA_55AA);
        send(CMD_SEARCH,     0, 12345);
        // Delete from the middle, the head, a missing key, then both ends
        send(CMD_DEL_KEY,    0, 32'sh8000_0000);
        send(CMD_DEL_KEY,    0, 5);
        send(CMD_DEL_KEY,    0, 12345);
        send(CMD_DEL_FRONT,  0, 0);
        send(CMD_DEL_BACK,   0, 0);
        send(CMD_READ_ALL,   0, 0);
        // Reserved codes are dropped without a result
        send(CMD_RESERVED_MIN, 3, 3);
        send(CMD_RESERVED_MAX, -1, -1);

        // Random blocks: fill to capacity, mix, drain, regrow
        for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
            steady = (blk == STEADY_BLOCK);
            if (blk == HOLD_BLOCK) hold_req = 1'b1;
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                send(pick_command(INSERT_SHARE[blk]), pick_value(), pick_key());
            end
        end
        steady = 1'b0;
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;

        // Drain, then give the block time to show any stray result
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands (%0d reserved codes dropped), checked %0d results.",
                 board.cmds_taken, board.cmds_ignored, board.results_seen);
        $display("List peaked at %0d entries; %0d full, %0d empty and %0d key-miss rejects.",
                 board.peak_depth, board.full_rejects, board.empty_rejects,
                 board.key_misses);
        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
